@@ hw/rtl/via_tsr_pkg.sv @@
// via_tsr_pkg: shared types and codes for the via timers and shift register block
// holds command, register index and shift mode codes plus the state, config
// and item structs; no dependencies
package via_tsr_pkg;

    localparam int CMD_W        = 2;
    localparam int VALUE_W      = 16;
    localparam int SHIFT_W      = 8;
    localparam int SCOUNT_W     = 4;
    localparam int SMODE_W      = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int RESULT_W     = 44;
    localparam int M_TDATA_W    = 48;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_T1    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_T2    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_SHIFT = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_T1_FREE_RUN   = 0;
    localparam int unsigned CFG_T1_LATCH      = 1;
    localparam int unsigned CFG_T2_PULSE_MODE = 2;
    localparam int unsigned CFG_SHIFT_MODE    = 3;

    // shift control modes
    localparam logic [SMODE_W-1:0] SHIFT_OFF   = 3'd0;
    localparam logic [SMODE_W-1:0] SHIFT_RIGHT = 3'd1;
    localparam logic [SMODE_W-1:0] SHIFT_LEFT  = 3'd6;

    localparam logic [SCOUNT_W-1:0] SHIFT_COUNT_FULL = 4'd8;

    typedef struct packed {
        logic                 t1_free_run;
        logic [VALUE_W-1:0]   t1_latch;
        logic                 t2_pulse_mode;
        logic [SMODE_W-1:0]   shift_mode;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [VALUE_W-1:0]   load_value;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]   t1_count;
        logic [VALUE_W-1:0]   t2_count;
        logic                 t1_done;
        logic                 t2_done;
        logic                 shift_done;
        logic [SHIFT_W-1:0]   shift_bits;
        logic [SCOUNT_W-1:0]  shifts_left;
        logic                 sclk_level;
        logic                 blank_out;
    } state_t;

endpackage

@@ hw/rtl/via_timers_and_shift_register.sv @@
// via_timers_and_shift_register: top level of the via timers and shift register block
// instantiates via_tsr_in_reg and via_tsr_step; uses via_tsr_pkg
//
// usage
//   slave channel: one transaction per command. s_tuser carries the command
//   (tick, load timer 1, load timer 2, load shift register), s_tdata the load
//   value. every command gives exactly one result transaction on the master
//   channel with the flags, both counters and the shift register contents
//   as they stand after that command.
//   config channel: cfg_index selects t1_free_run, t1_latch, t2_pulse_mode or
//   shift_mode; cfg_ready is always high, other indexes are ignored. write
//   only while no command is in flight.
//   path: slave acceptance goes through the input register, then the result
//   register that also updates the timer state, and on to m_tvalid.
//   throughput: one command per cycle unless the output stalls; the state
//   loop has no pipeline register, so back-to-back ticks advance the counters every clock.
//   stall: a held result keeps m_tdata stable; one more command waits in the
//   input register, after which s_tready drops until m_tready returns.
//   reset: aresetn low (synchronous) empties both stages, clears the config,
//   zeroes the counters and shift state and sets both timer flags.
module via_timers_and_shift_register
    import via_tsr_pkg::*;
#(
    parameter int CFG_INDEX_W = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // slave channel
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [CMD_W-1:0]        s_tuser,   // [1:0] cmd
    input  logic [VALUE_W-1:0]      s_tdata,   // [15:0] load_value
    // master channel
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [0] t1_flag, [1] t2_flag, [2] shift_flag, [3] blank_level,
    // [19:4] t1_count, [35:20] t2_count, [43:36] shift_data, [47:44] zero
    output logic [M_TDATA_W-1:0]    m_tdata,
    // configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // state after reset: counters and shift state zero, both timer flags set
    localparam state_t STATE_RESET = '{
        t1_count:    '0,
        t2_count:    '0,
        t1_done:     1'b1,
        t2_done:     1'b1,
        shift_done:  1'b0,
        shift_bits:  '0,
        shifts_left: '0,
        sclk_level:  1'b0,
        blank_out:   1'b0
    };

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    item_t  item;
    logic   item_valid;
    logic   advance;

    logic                 m_tvalid_reg;
    logic [RESULT_W-1:0]  result_reg;
    logic [RESULT_W-1:0]  result_next;

    // result register frees up when empty or being taken this cycle
    assign advance = !m_tvalid_reg || m_tready;

    via_tsr_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    via_tsr_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (item),
        .state_next (state_next)
    );

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_INDEX_W'(CFG_T1_FREE_RUN):   cfg_reg.t1_free_run   <= cfg_data[0];
                CFG_INDEX_W'(CFG_T1_LATCH):      cfg_reg.t1_latch      <= cfg_data;
                CFG_INDEX_W'(CFG_T2_PULSE_MODE): cfg_reg.t2_pulse_mode <= cfg_data[0];
                CFG_INDEX_W'(CFG_SHIFT_MODE):    cfg_reg.shift_mode    <= cfg_data[SMODE_W-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // timer and shift state, updated once per command leaving the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance && item_valid) begin
            state_reg <= state_next;
        end
    end

    assign result_next = {state_next.shift_bits,
                          state_next.t2_count,
                          state_next.t1_count,
                          state_next.blank_out,
                          state_next.shift_done,
                          state_next.t2_done,
                          state_next.t1_done};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && item_valid) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), result_reg};

endmodule

@@ hw/rtl/via_tsr_in_reg.sv @@
// via_tsr_in_reg: input register stage of the via timers and shift register block
// captures one transaction from the slave channel; uses via_tsr_pkg
module via_tsr_in_reg
    import via_tsr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CMD_W-1:0]    s_tuser,
    input  logic [VALUE_W-1:0]  s_tdata,
    input  logic                advance,
    output logic                item_valid,
    output item_t               item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.cmd        <= s_tuser;
            item_reg.load_value <= s_tdata;
        end
    end

endmodule

@@ hw/rtl/via_tsr_step.sv @@
// via_tsr_step: next-state logic for one command of the via timers and shift register
// pure combinational; uses via_tsr_pkg
module via_tsr_step
    import via_tsr_pkg::*;
(
    input  cfg_t   cfg,
    input  state_t state_cur,
    input  item_t  item,
    output state_t state_next
);

    always_comb begin
        state_t s;
        logic   shift_run;
        logic   go_right;
        s         = state_cur;
        shift_run = 1'b0;
        go_right  = 1'b0;
        case (item.cmd)
            CMD_TICK: begin
                // timer 1
                if (cfg.t1_free_run) begin
                    if (state_cur.t1_count == '0) begin
                        s.t1_done  = 1'b1;
                        s.t1_count = cfg.t1_latch;
                    end else begin
                        s.t1_count = state_cur.t1_count - VALUE_W'(1);
                    end
                end else if (!state_cur.t1_done) begin
                    if (state_cur.t1_count == '0) begin
                        s.t1_done = 1'b1;
                    end else begin
                        s.t1_count = state_cur.t1_count - VALUE_W'(1);
                    end
                end
                // timer 2, pulse mode holds
                if (!cfg.t2_pulse_mode) begin
                    if (state_cur.t2_count == '0) begin
                        s.t2_done = 1'b1;
                    end else if (!state_cur.t2_done) begin
                        s.t2_count = state_cur.t2_count - VALUE_W'(1);
                    end
                end
                // shift register
                case (cfg.shift_mode)
                    SHIFT_OFF: begin
                        s.shift_done  = 1'b0;
                        s.shifts_left = '0;
                    end
                    SHIFT_RIGHT: begin
                        shift_run = 1'b1;
                        go_right  = 1'b1;
                    end
                    SHIFT_LEFT: begin
                        shift_run = 1'b1;
                    end
                    default: begin
                        shift_run = 1'b0;
                    end
                endcase
                if (shift_run && state_cur.shifts_left != '0) begin
                    s.sclk_level = !state_cur.sclk_level;
                    // shift on the falling edge of the shift clock
                    if (state_cur.sclk_level) begin
                        if (go_right) begin
                            s.blank_out  = state_cur.shift_bits[0];
                            s.shift_bits = {state_cur.shift_bits[0],
                                            state_cur.shift_bits[SHIFT_W-1:1]};
                        end else begin
                            s.blank_out  = state_cur.shift_bits[SHIFT_W-1];
                            s.shift_bits = {state_cur.shift_bits[SHIFT_W-2:0],
                                            state_cur.shift_bits[SHIFT_W-1]};
                        end
                        s.shifts_left = state_cur.shifts_left - SCOUNT_W'(1);
                        if (state_cur.shifts_left == SCOUNT_W'(1)) begin
                            s.shift_done = 1'b1;
                        end
                    end
                end
            end
            CMD_LOAD_T1: begin
                s.t1_count = item.load_value;
                s.t1_done  = 1'b0;
            end
            CMD_LOAD_T2: begin
                s.t2_count = item.load_value;
                s.t2_done  = 1'b0;
            end
            CMD_LOAD_SHIFT: begin
                s.shift_bits  = item.load_value[SHIFT_W-1:0];
                s.shifts_left = SHIFT_COUNT_FULL;
                s.shift_done  = 1'b0;
            end
            default: begin
                s = state_cur;
            end
        endcase
        state_next = s;
    end

endmodule

@@ hw/rtl/via_tsr_checker.sv @@
// via_tsr_checker: port-level assertions for via_timers_and_shift_register
// bound to the top level; uses via_tsr_pkg for widths
module via_tsr_checker
    import via_tsr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata
);

    // transactions accepted but not yet delivered, at most two in flight
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (s_fire && !m_fire) begin
            pending_next = pending_reg + 2'd1;
        end else if (m_fire && !s_fire) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire |-> pending_reg != 2'd0)
        else $error("result without a pending command");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("more commands in flight than stages");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // first edge out of reset shows an empty result stage
    a_reset_empty: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind via_timers_and_shift_register via_tsr_checker u_via_tsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/tb.sv @@
// tb: self-checking testbench for via_timers_and_shift_register
// drives commands and config writes, predicts every result and compares it
// field by field; depends on via_tsr_pkg and the rtl top level only
module tb;
    import via_tsr_pkg::*;

    localparam int          LONG_HOLD        = 300;   // receiver hold-off in cycles
    localparam int          STALL_LIMIT      = 4000;  // cycles with no transaction at all
    localparam int          SETTLE_CYCLES    = 6;     // settling wait after each drain, in cycles
    localparam int unsigned CFG_UNUSED_INDEX = 4;     // no register behind this index

    // one result as packed in m_tdata, lowest field last
    typedef struct packed {
        logic [SHIFT_W-1:0] shift_data;
        logic [VALUE_W-1:0] t2_count;
        logic [VALUE_W-1:0] t1_count;
        logic               blank_level;
        logic               shift_flag;
        logic               t2_flag;
        logic               t1_flag;
    } via_result_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // dut ports, all driven to known values from time zero
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [CMD_W-1:0]       s_tuser   = '0;    // [1:0] cmd
    logic [VALUE_W-1:0]     s_tdata   = '0;    // [15:0] load_value
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [0] t1_flag, [1] t2_flag, [2] shift_flag, [3] blank_level,
    // [19:4] t1_count, [35:20] t2_count, [43:36] shift_data, [47:44] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [7:0]             cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    via_timers_and_shift_register dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // pending commands and predicted results
    item_t       cmd_q[$];
    via_result_t result_q[$];

    // run control shared between processes
    logic in_fire       = 1'b0;  // input transaction at the last rising edge
    logic idle_on       = 1'b1;  // random idling allowed
    int   idle_odds     = 10;    // a burst starts with chance one in idle_odds
    int   hold_requests = 0;     // long receiver hold-offs asked by the stimulus
    int   hold_served   = 0;
    int   err_count     = 0;
    int   stall_cycles  = 0;
    int   n_ticks       = 0;
    int   n_loads       = 0;
    int   n_results     = 0;
    int   n_shift_flags = 0;
    int   n_phases      = 0;

    // predictor configuration
    logic               vm_free_run;
    logic [VALUE_W-1:0] vm_latch;
    logic               vm_pulse;
    logic [SMODE_W-1:0] vm_smode;

    // predictor state
    logic [VALUE_W-1:0]  vm_t1;
    logic [VALUE_W-1:0]  vm_t2;
    logic                vm_t1_done;
    logic                vm_t2_done;
    logic                vm_sh_done;
    logic [SHIFT_W-1:0]  vm_sh_bits;
    logic [SCOUNT_W-1:0] vm_sh_left;
    logic                vm_sclk;
    logic                vm_blank;

    task automatic via_model_reset();
        vm_free_run = 1'b0;
        vm_latch    = '0;
        vm_pulse    = 1'b0;
        vm_smode    = SHIFT_OFF;
        vm_t1       = '0;
        vm_t2       = '0;
        vm_t1_done  = 1'b1;
        vm_t2_done  = 1'b1;
        vm_sh_done  = 1'b0;
        vm_sh_bits  = '0;
        vm_sh_left  = '0;
        vm_sclk     = 1'b0;
        vm_blank    = 1'b0;
    endtask

    task automatic via_model_config(input logic [7:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_T1_FREE_RUN:   vm_free_run = data[0];
            CFG_T1_LATCH:      vm_latch    = data;
            CFG_T2_PULSE_MODE: vm_pulse    = data[0];
            CFG_SHIFT_MODE:    vm_smode    = data[SMODE_W-1:0];
            default: ;
        endcase
    endtask

    // applies one command to the predicted state and returns the state it leaves
    function automatic via_result_t via_next_state(input item_t it);
        via_result_t r;
        case (it.cmd)
            CMD_TICK: begin
                // timer 1: free-run reloads at zero, one-shot freezes once flagged
                if (vm_free_run) begin
                    if (vm_t1 == '0) begin
                        vm_t1_done = 1'b1;
                        vm_t1      = vm_latch;
                    end else begin
                        vm_t1 = vm_t1 - 1'b1;
                    end
                end else if (!vm_t1_done) begin
                    if (vm_t1 == '0) vm_t1_done = 1'b1;
                    else vm_t1 = vm_t1 - 1'b1;
                end
                // timer 2: pulse mode holds everything
                if (!vm_pulse) begin
                    if (vm_t2 == '0) vm_t2_done = 1'b1;
                    else if (!vm_t2_done) vm_t2 = vm_t2 - 1'b1;
                end
                // shift register: shifts on the falling edge of its own clock
                if (vm_smode == SHIFT_OFF) begin
                    vm_sh_done = 1'b0;
                    vm_sh_left = '0;
                end else if ((vm_smode == SHIFT_RIGHT || vm_smode == SHIFT_LEFT)
                             && vm_sh_left != '0) begin
                    vm_sclk = ~vm_sclk;
                    if (!vm_sclk) begin
                        if (vm_smode == SHIFT_RIGHT) begin
                            vm_blank   = vm_sh_bits[0];
                            vm_sh_bits = {vm_sh_bits[0], vm_sh_bits[SHIFT_W-1:1]};
                        end else begin
                            vm_blank   = vm_sh_bits[SHIFT_W-1];
                            vm_sh_bits = {vm_sh_bits[SHIFT_W-2:0], vm_sh_bits[SHIFT_W-1]};
                        end
                        vm_sh_left = vm_sh_left - 1'b1;
                        if (vm_sh_left == '0) vm_sh_done = 1'b1;
                    end
                end
            end
            CMD_LOAD_T1: begin
                vm_t1      = it.load_value;
                vm_t1_done = 1'b0;
            end
            CMD_LOAD_T2: begin
                vm_t2      = it.load_value;
                vm_t2_done = 1'b0;
            end
            default: begin
                // shift load keeps the shift clock level as it was
                vm_sh_bits = it.load_value[SHIFT_W-1:0];
                vm_sh_left = SHIFT_COUNT_FULL;
                vm_sh_done = 1'b0;
            end
        endcase
        r.t1_flag     = vm_t1_done;
        r.t2_flag     = vm_t2_done;
        r.shift_flag  = vm_sh_done;
        r.blank_level = vm_blank;
        r.t1_count    = vm_t1;
        r.t2_count    = vm_t2;
        r.shift_data  = vm_sh_bits;
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, seen);
            err_count++;
        end
    endtask

    // monitor: samples at the rising edge, checks results, predicts new ones
    always @(posedge aclk) begin
        via_result_t want;
        via_result_t seen;
        in_fire = s_tvalid && s_tready;
        if (m_tvalid && m_tready) begin
            n_results++;
            if (result_q.size() == 0) begin
                $error("result transaction with nothing expected, m_tdata %h", m_tdata);
                err_count++;
            end else begin
                want = result_q.pop_front();
                seen = via_result_t'(m_tdata[RESULT_W-1:0]);
                check_field("t1_flag", want.t1_flag, seen.t1_flag);
                check_field("t2_flag", want.t2_flag, seen.t2_flag);
                check_field("shift_flag", want.shift_flag, seen.shift_flag);
                check_field("blank_level", want.blank_level, seen.blank_level);
                check_field("t1_count", want.t1_count, seen.t1_count);
                check_field("t2_count", want.t2_count, seen.t2_count);
                check_field("shift_data", want.shift_data, seen.shift_data);
                check_field("pad", 0, m_tdata[M_TDATA_W-1:RESULT_W]);
                if (seen.shift_flag) n_shift_flags++;
            end
        end
        if (in_fire) begin
            if (s_tuser == CMD_TICK) n_ticks++;
            else n_loads++;
            result_q.push_back(via_next_state('{cmd: s_tuser, load_value: s_tdata}));
        end
        if (cfg_valid && cfg_ready) via_model_config(cfg_index, cfg_data);
        // watchdog on cycles where nothing moves
        if (in_fire || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // command driver: changes inputs at the falling edge
    int src_gap = 0;
    always @(negedge aclk) begin
        item_t it;
        if (!s_tvalid || in_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (idle_on && cmd_q.size() != 0
                         && $urandom_range(0, idle_odds - 1) == 0) begin
                // start an idle burst, this one included, with src_gap drawn at random
                src_gap = $urandom_range(0, 17);
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                it = cmd_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.cmd;
                s_tdata  <= it.load_value;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stall bursts plus long hold-offs on request
    int sink_gap  = 0;
    int sink_hold = 0;
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            sink_hold = LONG_HOLD;
        end
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, idle_odds - 1) == 0) begin
            sink_gap = $urandom_range(0, 17);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
        cmd_q.push_back('{cmd: cmd, load_value: value});
    endtask

    task automatic cfg_write(input int unsigned idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[7:0];
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic free_run, input logic [VALUE_W-1:0] latch,
                              input logic pulse, input logic [SMODE_W-1:0] smode);
        cfg_write(CFG_T1_FREE_RUN, {15'd0, free_run});
        cfg_write(CFG_T1_LATCH, latch);
        cfg_write(CFG_T2_PULSE_MODE, {15'd0, pulse});
        cfg_write(CFG_SHIFT_MODE, {13'd0, smode});
        n_phases++;
    endtask

    // sender pauses until every command went in and every result came back
    task automatic drain();
        while (cmd_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return VALUE_W'($urandom_range(0, 24));
        if (r < 55) return '1;
        if (r < 60) return '0;
        return VALUE_W'($urandom_range(0, 65535));
    endfunction

    // random commands: mostly ticks, some loads, now and then a load
    // followed by a long run of ticks so counters and shifts run to the end
    task automatic push_random(input int count);
        int r;
        int run;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_cmd(logic'(r[0]) ? CMD_LOAD_SHIFT : CMD_LOAD_T1, pick_value());
                run = $urandom_range(10, 40);
                for (int k = 0; k < run; k++) push_cmd(CMD_TICK, VALUE_W'($urandom));
                i += run;
            end else if (r < 75) begin
                push_cmd(CMD_TICK, VALUE_W'($urandom));
            end else if (r < 84) begin
                push_cmd(CMD_LOAD_T1, pick_value());
            end else if (r < 93) begin
                push_cmd(CMD_LOAD_T2, pick_value());
            end else begin
                push_cmd(CMD_LOAD_SHIFT, pick_value());
            end
        end
    endtask

    initial begin
        via_model_reset();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config: one-shot timers, shift disabled
        push_cmd(CMD_TICK, '0);              // flags set out of reset
        push_cmd(CMD_LOAD_T1, 16'hFFFF);
        push_cmd(CMD_TICK, '0);
        push_cmd(CMD_LOAD_T1, '0);
        push_cmd(CMD_TICK, '1);              // zero counter sets the flag
        push_cmd(CMD_TICK, '0);              // frozen once flagged
        push_cmd(CMD_LOAD_T2, '0);
        push_cmd(CMD_TICK, '0);
        push_cmd(CMD_LOAD_T2, 16'hFFFF);
        push_cmd(CMD_TICK, '0);
        push_cmd(CMD_LOAD_SHIFT, 16'hFFFF);  // high byte ignored
        push_cmd(CMD_TICK, '0);              // disabled mode clears the shift flag and the shift count
        drain();

        // free-run reload at the top of the range, pulse mode, rotate right
        set_config(1'b1, 16'hFFFF, 1'b1, SHIFT_RIGHT);
        cfg_write(CFG_UNUSED_INDEX, 16'hA5A5);
        push_cmd(CMD_LOAD_T1, '0);
        push_cmd(CMD_TICK, '0);              // reload from latch
        push_cmd(CMD_TICK, '0);
        push_cmd(CMD_LOAD_T2, 16'd5);
        push_cmd(CMD_TICK, '0);              // timer 2 holds
        push_cmd(CMD_LOAD_SHIFT, 16'h0081);
        for (int k = 0; k < 5; k++) push_cmd(CMD_TICK, '0);
        push_cmd(CMD_LOAD_SHIFT, 16'h00FF);  // reload mid-shift keeps clock level
        push_cmd(CMD_TICK, '0);
        drain();

        // random phases over several settings, extremes included
        set_config(1'b0, '0, 1'b0, SHIFT_LEFT);
        push_random(100);
        drain();

        // receiver holds off while commands keep coming so the input stalls
        set_config(1'b1, 16'hFFFF, 1'b1, SHIFT_RIGHT);
        hold_requests++;
        push_random(100);
        drain();

        set_config(1'b1, '0, 1'b0, SMODE_W'(7));
        idle_odds = 4;
        push_random(100);
        drain();

        set_config(1'b1, VALUE_W'($urandom_range(0, 30)), 1'b0, SHIFT_LEFT);
        idle_odds = 25;
        push_random(100);
        drain();

        set_config(1'b0, VALUE_W'($urandom), logic'($urandom_range(0, 1)),
                   SMODE_W'($urandom_range(0, 7)));
        idle_odds = 10;
        hold_requests++;
        push_random(100);
        drain();

        // last part runs back to back with no idling on either side
        set_config(1'b1, VALUE_W'($urandom_range(0, 30)), 1'b0, SHIFT_RIGHT);
        idle_on = 1'b0;
        push_random(100);
        drain();

        $display("covered %0d commands (%0d ticks, %0d loads) over %0d config settings",
                 n_ticks + n_loads, n_ticks, n_loads, n_phases);
        $display("checked %0d results, %0d with the shift flag set, %0d mismatches",
                 n_results, n_shift_flags, err_count);
        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
